@@ hdl/ttpu_pkg.sv @@
// Package: shared constants and types of the timing protection unit.
package ttpu_pkg;
    localparam int TASKS_DEF = 16;
    localparam int DOGS_DEF = 4;
    localparam int TIME_BITS_DEF = 32;
    localparam int CMD_W = 3;
    localparam int TASK_W = 4;
    localparam int DOG_W = 2;
    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        CMD_ACTIVATE = 3'd0,
        CMD_RESET_DOGS = 3'd1,
        CMD_START = 3'd2,
        CMD_PREEMPT = 3'd3,
        CMD_TERMINATE = 3'd4,
        CMD_EXPIRE = 3'd5,
        CMD_SET_LIMITS = 3'd6,
        CMD_SET_DOG = 3'd7
    } cmd_t;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_TIME = 2'd1;
    localparam logic [1:0] FAULT_LOCK = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TASK,
        ST_DOGS,
        ST_DONE
    } state_t;
endpackage

@@ hdl/task_timing_protection_unit.sv @@
// Top level: timing protection unit with task and watchdog memories.
//
//  channel | direction | contents
//  s_axis  | in        | tdata: cmd, task_index, time_now, dog_index, budget_value,
//          |           |        frame_value, enable_flag (from bit 0 up)
//  m_axis  | out       | tdata: accepted, arm, arm_delay, cancel, fault, dog_chosen
//
// The block takes a new item only in idle, after the result of the last one is taken.
// The task entry is read at the accepting edge and used in the next cycle. Start and
// preempt on a protected task then walk the watchdog entries in order; each entry is read
// from a registered port ahead of its update. The done state presents the result, and the
// block returns to idle. Reset clears the valid bits of the task and watchdog entries at
// once, so no clearing pass is needed. A stalled result holds the block in its final state.
module task_timing_protection_unit #(
    parameter int TASKS = ttpu_pkg::TASKS_DEF,
    parameter int DOGS = ttpu_pkg::DOGS_DEF,
    parameter int TIME_BITS = ttpu_pkg::TIME_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], task_index[6:3], time_now[38:7], dog_index[40:39],
    // budget_value[72:41], frame_value[104:73], enable_flag[105], zero fill
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted[0], arm[1], arm_delay[33:2], cancel[34], fault[36:35],
    // dog_chosen[38:37], zero fill
    output logic [39:0]  m_axis_tdata
);
    localparam int TI_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int DI_W = (DOGS > 1) ? $clog2(DOGS) : 1;
    localparam int EN = TASKS << DI_W;
    localparam int E_W = TI_W + DI_W;
    localparam logic [TIME_BITS-1:0] TZ = '0;
    localparam logic [TIME_BITS-1:0] DLY_MAX = TIME_BITS'(33'h0_FFFF_FFFF);

    ttpu_pkg::state_t st_reg;

    // Item registers.
    logic [2:0] cmd_reg;
    logic [3:0] task_reg;
    logic [TIME_BITS-1:0] now_reg, bud_reg, frm_reg;
    logic [1:0] dog_reg;
    logic en_reg;

    // Task memory and valid bits.
    logic [TIME_BITS-1:0] flen_mem [TASKS];
    logic [TIME_BITS-1:0] ebud_mem [TASKS];
    logic [TIME_BITS-1:0] fst_mem [TASKS];
    logic [TASKS-1:0] tval_reg, prot_reg, first_reg;
    logic [TIME_BITS-1:0] flen_q, ebud_q, fst_q;

    // Watchdog memories for remaining budget and start stamp, with per-entry bits.
    logic [TIME_BITS-1:0] rem_mem [EN];
    logic [TIME_BITS-1:0] sta_mem [EN];
    logic [EN-1:0] rval_reg, sval_reg, act_reg;
    logic [TIME_BITS-1:0] rem_q, sta_q;

    logic [TI_W-1:0] own_task_reg;
    logic [DI_W-1:0] own_dog_reg;
    logic own_valid_reg;

    logic [DI_W:0] d_reg;      // watchdog walk counter (read address)
    logic [DI_W-1:0] m_reg;
    logic [TIME_BITS-1:0] mrem_reg;

    logic acc_reg, arm_reg, can_reg;
    logic [1:0] flt_reg, chs_reg;
    logic [TIME_BITS-1:0] dly_reg;
    logic acc_next, can_next;
    logic [1:0] flt_next;

    wire ti_ok = ({28'd0, task_reg} < TASKS);
    wire [TI_W-1:0] ti = TI_W'(task_reg);
    wire prot = ti_ok && prot_reg[ti];
    // The task entry is read at the accepting edge, straight from the incoming item.
    wire [TI_W-1:0] tra = (st_reg == ttpu_pkg::ST_IDLE) ? TI_W'(s_axis_tdata[6:3]) : ti;
    wire [TI_W-1:0] wt = (cmd_reg == ttpu_pkg::CMD_EXPIRE) ? own_task_reg : ti;
    wire [DI_W-1:0] dcur = DI_W'(d_reg - 1'b1);
    wire [E_W-1:0] ecur = {wt, dcur};
    wire [E_W-1:0] erd = {wt, d_reg[DI_W-1:0]};
    wire [TIME_BITS-1:0] rem = rval_reg[ecur] ? rem_q : TZ;
    wire [TIME_BITS-1:0] sta = sval_reg[ecur] ? sta_q : TZ;
    wire [TIME_BITS-1:0] el = now_reg - sta;
    wire [TIME_BITS-1:0] fl = tval_reg[ti] ? flen_q : TZ;
    wire [TIME_BITS-1:0] eb = tval_reg[ti] ? ebud_q : TZ;
    wire [TIME_BITS-1:0] fs = tval_reg[ti] ? fst_q : TZ;
    wire [TIME_BITS-1:0] since = now_reg - fs;
    wire act_ok = (since > fl) || first_reg[ti];
    wire go_walk = prot && ((cmd_reg == ttpu_pkg::CMD_START) ||
                            (cmd_reg == ttpu_pkg::CMD_PREEMPT));
    wire own_on = own_valid_reg && prot_reg[own_task_reg];
    wire own_any = |((act_reg >> {own_task_reg, DI_W'(0)}) & EN'((1 << DOGS) - 1));
    wire [31:0] dly_out = (dly_reg > DLY_MAX) ? 32'hFFFF_FFFF : 32'(dly_reg);

    assign s_axis_tready = aresetn && (st_reg == ttpu_pkg::ST_IDLE);
    assign m_axis_tvalid = (st_reg == ttpu_pkg::ST_DONE);
    assign m_axis_tdata = {1'b0, chs_reg, flt_reg, can_reg, dly_out, arm_reg, acc_reg};

    // Result flags that are settled in the task cycle.
    always_comb begin
        acc_next = 1'b1;
        can_next = 1'b0;
        flt_next = ttpu_pkg::FAULT_NONE;
        if (cmd_reg == ttpu_pkg::CMD_ACTIVATE && prot && !act_ok) acc_next = 1'b0;
        if (cmd_reg == ttpu_pkg::CMD_PREEMPT && prot) can_next = 1'b1;
        if (cmd_reg == ttpu_pkg::CMD_TERMINATE && prot) can_next = act_reg[{ti, DI_W'(0)}];
        if (cmd_reg == ttpu_pkg::CMD_EXPIRE && own_on && own_any)
            flt_next = (own_dog_reg == '0) ? ttpu_pkg::FAULT_TIME : ttpu_pkg::FAULT_LOCK;
    end

    always_ff @(posedge aclk) begin
        flen_q <= flen_mem[tra];
        ebud_q <= ebud_mem[tra];
        fst_q <= fst_mem[tra];
        rem_q <= rem_mem[erd];
        sta_q <= sta_mem[erd];
        if (s_axis_tready && s_axis_tvalid) begin
            cmd_reg <= s_axis_tdata[2:0];
            task_reg <= s_axis_tdata[6:3];
            now_reg <= TIME_BITS'(s_axis_tdata[38:7]);
            dog_reg <= s_axis_tdata[40:39];
            bud_reg <= TIME_BITS'(s_axis_tdata[72:41]);
            frm_reg <= TIME_BITS'(s_axis_tdata[104:73]);
            en_reg <= s_axis_tdata[105];
        end
        if (!aresetn) begin
            st_reg <= ttpu_pkg::ST_IDLE;
            tval_reg <= '0; prot_reg <= '0; first_reg <= '1;
            rval_reg <= '0; sval_reg <= '0; act_reg <= '0;
            own_task_reg <= '0; own_dog_reg <= '0; own_valid_reg <= 1'b1;
            d_reg <= '0;
        end else begin
            unique case (st_reg)
                ttpu_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) st_reg <= ttpu_pkg::ST_TASK;
                end
                ttpu_pkg::ST_TASK: begin
                    // Task entry is now readable; settle everything but the walk.
                    acc_reg <= acc_next; arm_reg <= 1'b0; can_reg <= can_next;
                    flt_reg <= flt_next; chs_reg <= 2'd0; dly_reg <= TZ;
                    m_reg <= '0;
                    if (go_walk) begin
                        d_reg <= (DI_W+1)'(1);
                        st_reg <= ttpu_pkg::ST_DOGS;
                    end else begin
                        st_reg <= ttpu_pkg::ST_DONE;
                    end
                    unique case (cmd_reg)
                        ttpu_pkg::CMD_ACTIVATE: if (prot && act_ok) begin
                            fst_mem[ti] <= now_reg;
                            if (!tval_reg[ti]) begin
                                flen_mem[ti] <= TZ; ebud_mem[ti] <= TZ;
                            end
                            tval_reg[ti] <= 1'b1;
                            first_reg[ti] <= 1'b0;
                        end
                        ttpu_pkg::CMD_RESET_DOGS: if (prot) begin
                            for (int k = 0; k < DOGS; k++)
                                act_reg[{ti, DI_W'(k)}] <= (k == 0);
                        end
                        ttpu_pkg::CMD_START, ttpu_pkg::CMD_PREEMPT: begin
                        end
                        ttpu_pkg::CMD_TERMINATE: if (prot) begin
                            rem_mem[{ti, DI_W'(0)}] <= eb;
                            rval_reg[{ti, DI_W'(0)}] <= 1'b1;
                        end
                        ttpu_pkg::CMD_EXPIRE: if (own_on) begin
                            for (int k = 0; k < DOGS; k++)
                                act_reg[{own_task_reg, DI_W'(k)}] <= 1'b0;
                        end
                        ttpu_pkg::CMD_SET_LIMITS: if (ti_ok) begin
                            flen_mem[ti] <= frm_reg; ebud_mem[ti] <= bud_reg;
                            if (!tval_reg[ti]) fst_mem[ti] <= TZ;
                            tval_reg[ti] <= 1'b1;
                            prot_reg[ti] <= en_reg;
                        end
                        default: if (ti_ok && {30'd0, dog_reg} < DOGS) begin
                            rem_mem[{ti, dog_reg[DI_W-1:0]}] <= bud_reg;
                            rval_reg[{ti, dog_reg[DI_W-1:0]}] <= 1'b1;
                            act_reg[{ti, dog_reg[DI_W-1:0]}] <= en_reg;
                        end
                    endcase
                end
                ttpu_pkg::ST_DOGS: begin
                    // The read data holds entry d_reg-1, read through the registered port.
                    if (cmd_reg == ttpu_pkg::CMD_START) begin
                        if (dcur == '0) mrem_reg <= rem;
                        if (act_reg[ecur]) begin
                            sta_mem[ecur] <= now_reg;
                            sval_reg[ecur] <= 1'b1;
                            if (dcur != '0 && rem < mrem_reg) begin
                                m_reg <= dcur; mrem_reg <= rem;
                            end
                        end
                    end else if (act_reg[ecur]) begin
                        rem_mem[ecur] <= (rem > el) ? rem - el : TZ;
                        rval_reg[ecur] <= 1'b1;
                    end
                    if (d_reg == (DI_W+1)'(DOGS)) begin
                        st_reg <= ttpu_pkg::ST_DONE;
                        d_reg <= '0;
                        if (cmd_reg == ttpu_pkg::CMD_START) begin
                            // Final choice includes the last entry.
                            if (DOGS > 1 && act_reg[ecur] && rem < mrem_reg) begin
                                chs_reg <= 2'(dcur); own_dog_reg <= dcur; dly_reg <= rem;
                            end else if (DOGS == 1) begin
                                chs_reg <= 2'd0; own_dog_reg <= '0; dly_reg <= rem;
                            end else begin
                                chs_reg <= 2'(m_reg); own_dog_reg <= m_reg;
                                dly_reg <= mrem_reg;
                            end
                            arm_reg <= 1'b1;
                            own_task_reg <= ti;
                            own_valid_reg <= 1'b1;
                        end
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                default: begin
                    if (m_axis_tready) st_reg <= ttpu_pkg::ST_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sim/testbench.sv @@
// Testbench for the task timing protection unit: directed table, then random items.
`timescale 1ns / 1ps

module testbench;
    localparam int NTASK = 16;
    localparam int NDOG = 4;
    localparam int RANDOM_ITEMS = 1300;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        enable_flag;
        logic [31:0] frame_value;
        logic [31:0] budget_value;
        logic [1:0]  dog_index;
        logic [31:0] time_now;
        logic [3:0]  task_index;
        ttpu_pkg::cmd_t cmd;
    } item_t;

    typedef struct packed {
        logic [1:0]  dog_chosen;
        logic [1:0]  fault;
        logic        cancel;
        logic [31:0] arm_delay;
        logic        arm;
        logic        accepted;
    } verdict_t;

    typedef struct {
        item_t    stim;
        logic     has_known;
        verdict_t known;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;

    task_timing_protection_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the protection tables.
    logic [31:0] frame_len [NTASK];
    logic [31:0] exec_bud [NTASK];
    logic        prot_on [NTASK];
    logic        first_act [NTASK];
    logic [31:0] frame_t0 [NTASK];
    logic [31:0] remain [NTASK][NDOG];
    logic [31:0] stamp [NTASK][NDOG];
    logic        live [NTASK][NDOG];
    logic [3:0]  owner_t;
    logic [1:0]  owner_d;

    verdict_t expected_q [$];
    int errors = 0;
    int idle_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Applies one item to the shadow tables and returns the result it must produce.
    function automatic verdict_t protect_step(item_t it);
        verdict_t v;
        logic [3:0] t;
        logic [1:0] m;
        logic [31:0] el;
        logic any;
        v = '0;
        v.accepted = 1'b1;
        t = it.task_index;
        case (it.cmd)
            ttpu_pkg::CMD_ACTIVATE: if (prot_on[t]) begin
                if ((it.time_now - frame_t0[t]) > frame_len[t] || first_act[t]) begin
                    frame_t0[t] = it.time_now;
                    first_act[t] = 1'b0;
                end else begin
                    v.accepted = 1'b0;
                end
            end
            ttpu_pkg::CMD_RESET_DOGS: if (prot_on[t]) begin
                for (int d = 0; d < NDOG; d++) live[t][d] = (d == 0);
            end
            ttpu_pkg::CMD_START: if (prot_on[t]) begin
                m = '0;
                for (int d = 0; d < NDOG; d++) begin
                    if (live[t][d]) begin
                        stamp[t][d] = it.time_now;
                        if (remain[t][d] < remain[t][m]) m = d[1:0];
                    end
                end
                owner_t = t;
                owner_d = m;
                v.arm = 1'b1;
                v.arm_delay = remain[t][m];
                v.dog_chosen = m;
            end
            ttpu_pkg::CMD_PREEMPT: if (prot_on[t]) begin
                v.cancel = 1'b1;
                for (int d = 0; d < NDOG; d++) begin
                    if (live[t][d]) begin
                        el = it.time_now - stamp[t][d];
                        remain[t][d] = (remain[t][d] > el) ? remain[t][d] - el : 32'd0;
                    end
                end
            end
            ttpu_pkg::CMD_TERMINATE: if (prot_on[t]) begin
                v.cancel = live[t][0];
                remain[t][0] = exec_bud[t];
            end
            ttpu_pkg::CMD_EXPIRE: if (prot_on[owner_t]) begin
                any = 1'b0;
                for (int d = 0; d < NDOG; d++) begin
                    any |= live[owner_t][d];
                    live[owner_t][d] = 1'b0;
                end
                if (any) v.fault = (owner_d == 2'd0) ? ttpu_pkg::FAULT_TIME
                                                     : ttpu_pkg::FAULT_LOCK;
            end
            ttpu_pkg::CMD_SET_LIMITS: begin
                frame_len[t] = it.frame_value;
                exec_bud[t] = it.budget_value;
                prot_on[t] = it.enable_flag;
            end
            default: begin
                remain[t][it.dog_index] = it.budget_value;
                live[t][it.dog_index] = it.enable_flag;
            end
        endcase
        return v;
    endfunction

    function automatic item_t make_item(ttpu_pkg::cmd_t c, int t, logic [31:0] tn, int d,
                                        logic [31:0] b, logic [31:0] f, logic en);
        item_t it;
        it.cmd = c;
        it.task_index = t[3:0];
        it.time_now = tn;
        it.dog_index = d[1:0];
        it.budget_value = b;
        it.frame_value = f;
        it.enable_flag = en;
        return it;
    endfunction

    // Random item: mostly protocol-like traffic on a few tasks, with a little noise.
    logic [31:0] clock_now = 32'd0;
    function automatic item_t random_item();
        item_t it;
        int r;
        r = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, 60);
        it = item_t'({$urandom, $urandom, $urandom, $urandom});
        if (r < 85) begin
            it.task_index = 4'($urandom_range(0, 3));
            it.time_now = clock_now;
            if ($urandom_range(0, 3) != 0) begin
                it.budget_value = $urandom_range(0, 200);
                it.frame_value = $urandom_range(0, 150);
            end
            if ($urandom_range(0, 9) != 0) it.enable_flag = 1'b1;
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata <= {6'd0, it};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        expected_q.push_back(protect_step(it));
    endtask

    task automatic check_result(verdict_t got, verdict_t want);
        if (got !== want) begin
            errors++;
            $display("%0t: result mismatch expected %h actual %h", $realtime, want, got);
        end
    endtask

    // Receiver: random stalls, and each accepted item compared with the oldest expectation.
    verdict_t known_q [$];
    logic     known_flag_q [$];
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result expected none actual %h",
                             $realtime, m_axis_tdata);
                end else begin
                    check_result(verdict_t'(m_axis_tdata[38:0]), expected_q.pop_front());
                    if (known_flag_q.size() > 0) begin
                        if (known_flag_q.pop_front())
                            check_result(verdict_t'(m_axis_tdata[38:0]), known_q.pop_front());
                        else
                            void'(known_q.pop_front());
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("task_timing_protection_unit test failed");
                $finish;
            end
        end
    end

    row_t rows [$];
    task automatic add_row(item_t it, logic has_k, verdict_t k);
        row_t r;
        r.stim = it;
        r.has_known = has_k;
        r.known = k;
        rows.push_back(r);
    endtask

    initial begin
        verdict_t ok;
        verdict_t none;
        verdict_t k;
        ok = '0;
        ok.accepted = 1'b1;
        none = '0;
        // Unprotected task after reset: no effect, accepted.
        add_row(make_item(ttpu_pkg::CMD_START, 15, 32'hFFFF_FFFF, 3, '1, '1, 1'b1), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_EXPIRE, 0, 0, 0, 0, 0, 0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_SET_LIMITS, 2, 0, 0, 32'd100, 32'd50, 1'b1), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_SET_DOG, 2, 0, 0, 32'hFFFF_FFFF, 0, 1'b1), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_SET_DOG, 2, 0, 1, 32'd40, 0, 1'b1), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_SET_DOG, 2, 0, 2, 32'd70, 0, 1'b0), 1'b1, ok);
        // First activation always accepted; a second within the frame refused.
        add_row(make_item(ttpu_pkg::CMD_ACTIVATE, 2, 32'd10, 0, 0, 0, 0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_ACTIVATE, 2, 32'd60, 0, 0, 0, 0), 1'b1, none);
        add_row(make_item(ttpu_pkg::CMD_ACTIVATE, 2, 32'd61, 0, 0, 0, 0), 1'b1, ok);
        k = ok; k.arm = 1'b1; k.arm_delay = 32'd40; k.dog_chosen = 2'd1;
        add_row(make_item(ttpu_pkg::CMD_START, 2, 32'd100, 0, 0, 0, 0), 1'b1, k);
        add_row(make_item(ttpu_pkg::CMD_PREEMPT, 2, 32'd130, 0, 0, 0, 0), 1'b0, ok);
        add_row(make_item(ttpu_pkg::CMD_START, 2, 32'd140, 0, 0, 0, 0), 1'b0, ok);
        // Preempt with wrapped elapsed time saturates the budgets at zero.
        add_row(make_item(ttpu_pkg::CMD_PREEMPT, 2, 32'd139, 0, 0, 0, 0), 1'b0, ok);
        add_row(make_item(ttpu_pkg::CMD_TERMINATE, 2, 32'd150, 0, 0, 0, 0), 1'b0, ok);
        add_row(make_item(ttpu_pkg::CMD_START, 2, 32'd160, 0, 0, 0, 0), 1'b0, ok);
        k = ok; k.fault = ttpu_pkg::FAULT_LOCK;
        add_row(make_item(ttpu_pkg::CMD_EXPIRE, 2, 0, 0, 0, 0, 0), 1'b1, k);
        // Expire with no live watchdog left: no fault.
        add_row(make_item(ttpu_pkg::CMD_EXPIRE, 2, 0, 0, 0, 0, 0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_TERMINATE, 2, 32'd170, 0, 0, 0, 0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_RESET_DOGS, 2, 0, 0, 0, 0, 0), 1'b1, ok);
        // Start with only watchdog 0 live: time fault on expiry.
        add_row(make_item(ttpu_pkg::CMD_START, 2, 32'd200, 0, 0, 0, 0), 1'b0, ok);
        k = ok; k.fault = ttpu_pkg::FAULT_TIME;
        add_row(make_item(ttpu_pkg::CMD_EXPIRE, 9, 0, 0, 0, 0, 0), 1'b1, k);
        add_row(make_item(ttpu_pkg::CMD_SET_LIMITS, 2, 0, 0, 0, 0, 1'b0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_ACTIVATE, 2, 0, 0, 0, 0, 0), 1'b1, ok);
        add_row(make_item(ttpu_pkg::CMD_SET_LIMITS, 2, 0, 0, 32'd5, 32'hFFFF_FFFF, 1'b1),
                1'b1, ok);

        for (int t = 0; t < NTASK; t++) begin
            frame_len[t] = '0; exec_bud[t] = '0; prot_on[t] = 1'b0;
            first_act[t] = 1'b1; frame_t0[t] = '0;
            for (int d = 0; d < NDOG; d++) begin
                remain[t][d] = '0; stamp[t][d] = '0; live[t][d] = 1'b0;
            end
        end
        owner_t = '0;
        owner_d = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            known_flag_q.push_back(rows[i].has_known);
            known_q.push_back(rows[i].known);
            send_item(rows[i].stim);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) send_item(random_item());
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("task_timing_protection_unit test passed");
        else
            $display("task_timing_protection_unit test failed");
        $finish;
    end
endmodule
